// File: src/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared constants and types for the text line folder.
// ----------------------------------------------------------------------------
package tlf_pkg;

    // line buffer geometry
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;

    // byte codes
    localparam logic [7:0] BYTE_NL    = 8'd10;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    // fold width register
    localparam int         FW_W     = 6;
    localparam logic [5:0] FW_RESET = 6'd63;
    localparam logic [5:0] FW_MIN   = 6'd2;

    // control sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// File: src/tlf_if.sv
// ----------------------------------------------------------------------------
// tlf_if
// Valid/ready channels of the text line folder: input bytes, output bytes,
// and the fold width write channel.
// ----------------------------------------------------------------------------

// input byte channel
interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// output byte channel
interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// fold width write channel
interface tlf_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [tlf_pkg::FW_W-1:0] fold_width;

    modport source (output valid, output fold_width, input ready);
    modport sink   (input valid, input fold_width, output ready);
endinterface

// File: src/tlf_ram.sv
// ----------------------------------------------------------------------------
// tlf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/text_line_folder_core.sv
// ----------------------------------------------------------------------------
// text_line_folder_core
// Folds a text byte stream into lines no longer than the fold width (widths below two act as two).
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one text byte per item. A newline (10) ends the current line.
//   o_out  : emitted bytes; last marks the final byte of the run caused by
//            one input item (always a newline).
//   i_cfg  : fold_width write, always ready; write only while idle.
// Pending bytes sit in a 64-entry circular RAM (head pointer plus count).
// An ordinary byte that does not fill the line leaves the core idle, so the
// next byte can be taken in the following cycle.
// A fold first scans RAM positions 1 to width-1 for the rightmost space,
// one read per cycle, then checks the last read and settles the cut. It
// then primes the RAM read and emits the segment at one byte per cycle
// through the output register while the receiver is ready, plus the newline.
// A newline flushes the pending bytes the same way without the scan.
// An empty line emits nothing and leaves the core idle.
// Input is held off (ready low) during a scan or an emission.
// A stalled receiver freezes emission; the RAM address is held so the
// prefetched byte stays valid. Synchronous reset empties the line buffer and
// sets fold_width to 63; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module text_line_folder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlf_in_if.sink    i_in,
    tlf_out_if.source o_out,
    tlf_cfg_if.sink   i_cfg
);

    // state registers
    tlf_pkg::t_state                r_state,    n_state;
    logic [tlf_pkg::FW_W-1:0]       r_fw,       n_fw;
    logic [tlf_pkg::ADDR_W-1:0]     r_head,     n_head;
    logic [tlf_pkg::CNT_W-1:0]      r_cnt,      n_cnt;
    logic [tlf_pkg::ADDR_W-1:0]     r_scan_pos, n_scan_pos;
    logic [tlf_pkg::ADDR_W-1:0]     r_chk_pos,  n_chk_pos;
    logic                           r_chk_v,    n_chk_v;
    logic [tlf_pkg::ADDR_W-1:0]     r_cut,      n_cut;
    logic [tlf_pkg::CNT_W-1:0]      r_len,      n_len;
    logic [tlf_pkg::CNT_W-1:0]      r_epos,     n_epos;
    logic                           r_qv,       n_qv;
    logic                           r_ov,       n_ov;
    logic                           r_olast,    n_olast;
    logic [7:0]                     r_obyte,    n_obyte;

    // RAM port signals
    logic                           ram_we;
    logic [tlf_pkg::ADDR_W-1:0]     ram_waddr;
    logic [tlf_pkg::ADDR_W-1:0]     ram_raddr;
    logic [7:0]                     ram_q;

    // helpers
    logic [tlf_pkg::FW_W-1:0]       eff_w;
    logic [tlf_pkg::CNT_W-1:0]      new_cnt;
    logic [tlf_pkg::CNT_W-1:0]      epos_inc;
    logic                           in_fire;
    logic                           out_free;
    logic                           issue;
    logic                           load;

    tlf_ram #(
        .WIDTH (8),
        .DEPTH (tlf_pkg::BUF_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.in_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // effective width: values below two act as two
    assign eff_w    = (r_fw < tlf_pkg::FW_MIN) ? tlf_pkg::FW_MIN : r_fw;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign epos_inc = r_epos + tlf_pkg::CNT_W'(1);
    assign ram_waddr = r_head + r_cnt[tlf_pkg::ADDR_W-1:0];

    assign i_in.ready     = (r_state == tlf_pkg::ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

    // next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_fw       = r_fw;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_scan_pos = r_scan_pos;
        n_chk_pos  = r_chk_pos;
        n_chk_v    = r_chk_v;
        n_cut      = r_cut;
        n_len      = r_len;
        n_epos     = r_epos;
        n_qv       = r_qv;
        n_ov       = r_ov;
        n_olast    = r_olast;
        n_obyte    = r_obyte;
        ram_we     = 1'b0;
        ram_raddr  = r_head;
        issue      = 1'b0;
        load       = 1'b0;
        new_cnt    = r_cnt;

        if (i_cfg.valid) begin
            n_fw = i_cfg.fold_width;
        end

        // output register drains when taken
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            tlf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.in_byte == tlf_pkg::BYTE_NL) begin
                        // flush the line, if any
                        if (r_cnt != '0) begin
                            n_len   = r_cnt;
                            n_epos  = '0;
                            n_qv    = 1'b0;
                            n_state = tlf_pkg::ST_EMIT;
                        end
                    end else begin
                        // append unless full
                        if (r_cnt < tlf_pkg::CNT_W'(tlf_pkg::BUF_DEPTH)) begin
                            ram_we  = 1'b1;
                            new_cnt = r_cnt + tlf_pkg::CNT_W'(1);
                        end
                        n_cnt = new_cnt;
                        if (new_cnt >= {1'b0, eff_w}) begin
                            n_scan_pos = tlf_pkg::ADDR_W'(1);
                            n_chk_v    = 1'b0;
                            n_cut      = '0;
                            n_state    = tlf_pkg::ST_SCAN;
                        end
                    end
                end
            end

            tlf_pkg::ST_SCAN: begin
                // one read per cycle at positions 1..w-1, check in the next cycle
                ram_raddr = r_head + r_scan_pos;
                issue     = (r_scan_pos < eff_w);
                if (issue) begin
                    n_scan_pos = r_scan_pos + tlf_pkg::ADDR_W'(1);
                end
                n_chk_pos = r_scan_pos;
                n_chk_v   = issue;
                if (r_chk_v && ram_q == tlf_pkg::BYTE_SPACE) begin
                    n_cut = r_chk_pos;
                end
                if (!issue && !r_chk_v) begin
                    n_len   = (r_cut != '0) ? ({1'b0, r_cut} + tlf_pkg::CNT_W'(1))
                                            : {1'b0, eff_w};
                    n_epos  = '0;
                    n_qv    = 1'b0;
                    n_state = tlf_pkg::ST_EMIT;
                end
            end

            tlf_pkg::ST_EMIT: begin
                // RAM q holds the byte at r_epos once r_qv is set
                n_qv = 1'b1;
                load = out_free && r_qv && (r_epos < r_len);
                ram_raddr = r_head + (load ? epos_inc[tlf_pkg::ADDR_W-1:0]
                                           : r_epos[tlf_pkg::ADDR_W-1:0]);
                if (load) begin
                    n_ov    = 1'b1;
                    n_obyte = ram_q;
                    n_olast = 1'b0;
                    n_epos  = epos_inc;
                end else if (out_free && !(r_epos < r_len)) begin
                    // closing newline, drop the emitted segment
                    n_ov    = 1'b1;
                    n_obyte = tlf_pkg::BYTE_NL;
                    n_olast = 1'b1;
                    n_head  = r_head + r_len[tlf_pkg::ADDR_W-1:0];
                    n_cnt   = r_cnt - r_len;
                    n_state = tlf_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tlf_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlf_pkg::ST_IDLE;
            r_fw    <= tlf_pkg::FW_RESET;
            r_head  <= '0;
            r_cnt   <= '0;
            r_chk_v <= 1'b0;
            r_qv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fw    <= n_fw;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_chk_v <= n_chk_v;
            r_qv    <= n_qv;
            r_ov    <= n_ov;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_scan_pos <= n_scan_pos;
        r_chk_pos  <= n_chk_pos;
        r_cut      <= n_cut;
        r_len      <= n_len;
        r_epos     <= n_epos;
        r_olast    <= n_olast;
        r_obyte    <= n_obyte;
    end

endmodule
